// ----- hw/rtl/asb_pkg.sv -----
package asb_pkg;

   // frame and sprite geometry
   localparam int FRAME_WIDTH     = 320;
   localparam int FRAME_HEIGHT    = 256;
   localparam int SPRITE_SIZE     = 32;
   localparam int FRAME_PIXELS    = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int SPRITE_TEXELS   = SPRITE_SIZE * SPRITE_SIZE;
   localparam int FRAME_ADDR_BITS = $clog2(FRAME_PIXELS);
   localparam int SPR_IDX_BITS    = $clog2(SPRITE_SIZE);
   localparam int SPR_ADDR_BITS   = 2 * SPR_IDX_BITS;
   localparam int SIZE_BITS       = $clog2(SPRITE_SIZE + 1);
   localparam int COL_BITS        = $clog2(FRAME_WIDTH);
   localparam int ROW_BITS        = $clog2(FRAME_HEIGHT);
   localparam int COORD_BITS      = 12;

   // item fields
   localparam int FUNC_BITS  = 2;
   localparam int ADDR_BITS  = 17;
   localparam int PIX_BITS   = 8;
   localparam int CX_BITS    = 9;
   localparam int CY_BITS    = 8;
   localparam int CFG_BITS   = 6;
   localparam int CSR_IDX_BITS = 4;

   localparam int ADDR_LSB  = 0;
   localparam int VALUE_LSB = ADDR_LSB + ADDR_BITS;
   localparam int CX_LSB    = VALUE_LSB + PIX_BITS;
   localparam int CY_LSB    = CX_LSB + CX_BITS;
   localparam int REQ_FIELD_BITS = CY_LSB + CY_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = PIX_BITS + 1;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [PIX_BITS-1:0] SAT_MAX = '1;

   localparam logic [CSR_IDX_BITS-1:0] REG_SPRITE_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SPRITE_HEIGHT = 4'd1;
   localparam logic [CFG_BITS-1:0]     SIZE_RESET        = 6'd32;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_SPRITE_WR = 2'd0,
      FUNC_FRAME_WR  = 2'd1,
      FUNC_BLIT      = 2'd2,
      FUNC_FRAME_RD  = 2'd3
   } asb_func_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic scan;
      logic result;
   } asb_cmd_type;

   typedef struct packed {
      asb_func_type func;
      logic         size_zero;
      logic         last_pixel;
   } asb_sts_type;

endpackage

// ----- hw/rtl/asb_ctrl.sv -----
module asb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output asb_pkg::asb_cmd_type cmd,
   input  asb_pkg::asb_sts_type sts
);
   import asb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      rsp_valid_ff;
   logic      drain_ff;

   assign req_tready = ready_ff;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.load   = req_tvalid && ready_ff;
      cmd.exec   = (state_ff == ST_DECODE);
      cmd.scan   = (state_ff == ST_SCAN);
      cmd.result = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ready_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         drain_ff     <= 1'b0;
      end else begin
         if (cmd.result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && ready_ff) begin
                  ready_ff <= 1'b0;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               if (sts.func == FUNC_BLIT && !sts.size_zero) begin
                  state_ff <= ST_SCAN;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_SCAN: begin
               if (sts.last_pixel) begin
                  drain_ff <= 1'b0;
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // wait here for the read and write-back stages to empty
               drain_ff <= 1'b1;
               if (drain_ff) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  ready_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- hw/rtl/asb_datapath.sv -----
module asb_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  asb_pkg::asb_cmd_type                 cmd,
   output asb_pkg::asb_sts_type                 sts,
   input  logic [asb_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   input  logic [asb_pkg::FUNC_BITS-1:0]        req_tuser,
   input  logic                                 csr_valid,
   input  logic [asb_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [asb_pkg::CFG_BITS-1:0]         csr_data,
   output logic [asb_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata
);
   import asb_pkg::*;

   // configuration
   logic [CFG_BITS-1:0] cfg_w_ff, cfg_h_ff;
   logic [SIZE_BITS-1:0] w_clamp, h_clamp;

   // latched item
   asb_func_type         func_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [PIX_BITS-1:0]  value_ff;
   logic [CX_BITS-1:0]   cx_ff;
   logic [CY_BITS-1:0]   cy_ff;

   // blit scan state
   logic [SIZE_BITS-1:0]    w_ff, h_ff;
   logic [SPR_IDX_BITS-1:0] r_ff, c_ff;
   logic signed [COORD_BITS-1:0] x0_ff, y0_ff;
   logic signed [COORD_BITS-1:0] x0_in, y0_in, fx, fy;
   logic c_last, r_last, inb;
   logic clip_ff;

   // pixel pipeline
   logic                       p1_valid_ff;
   logic [COL_BITS-1:0]        p1_fx_ff;
   logic [ROW_BITS-1:0]        p1_fy_ff;
   logic [SPR_ADDR_BITS-1:0]   p1_spr_ff;
   logic [FRAME_ADDR_BITS-1:0] p1_idx;
   logic                       p2_valid_ff;
   logic [FRAME_ADDR_BITS-1:0] p2_idx_ff;
   logic [PIX_BITS:0]          sum;
   logic [PIX_BITS-1:0]        sat;

   // memories
   logic [PIX_BITS-1:0] frame_mem [FRAME_PIXELS];
   logic [PIX_BITS-1:0] spr_mem [SPRITE_TEXELS];
   logic [PIX_BITS-1:0] frame_rd_ff, spr_rd_ff;
   logic                       fw_en, fr_en, sw_en;
   logic [FRAME_ADDR_BITS-1:0] fw_addr, fr_addr;
   logic [PIX_BITS-1:0]        fw_data;
   logic frame_in_range, spr_in_range;

   logic [PIX_BITS-1:0] rsp_data_ff;
   logic                rsp_clip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= SIZE_RESET;
         cfg_h_ff <= SIZE_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_SPRITE_WIDTH) begin
            cfg_w_ff <= csr_data;
         end
         if (csr_index == REG_SPRITE_HEIGHT) begin
            cfg_h_ff <= csr_data;
         end
      end
   end

   always_comb begin
      w_clamp = (int'(cfg_w_ff) > SPRITE_SIZE) ? SIZE_BITS'(SPRITE_SIZE)
                                               : SIZE_BITS'(cfg_w_ff);
      h_clamp = (int'(cfg_h_ff) > SPRITE_SIZE) ? SIZE_BITS'(SPRITE_SIZE)
                                               : SIZE_BITS'(cfg_h_ff);
      x0_in = $signed(COORD_BITS'(cx_ff)) - $signed(COORD_BITS'(w_clamp >> 1));
      y0_in = $signed(COORD_BITS'(cy_ff)) - $signed(COORD_BITS'(h_clamp >> 1));
      fx = x0_ff + $signed(COORD_BITS'(c_ff));
      fy = y0_ff + $signed(COORD_BITS'(r_ff));
      // negative coordinates compare as large unsigned values
      inb = ($unsigned(fx) < COORD_BITS'(FRAME_WIDTH)) &&
            ($unsigned(fy) < COORD_BITS'(FRAME_HEIGHT));
      c_last = (SIZE_BITS'(c_ff) == w_ff - SIZE_BITS'(1));
      r_last = (SIZE_BITS'(r_ff) == h_ff - SIZE_BITS'(1));
      sts.func       = func_ff;
      sts.size_zero  = (w_clamp == '0) || (h_clamp == '0);
      sts.last_pixel = c_last && r_last;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= asb_func_type'(req_tuser);
         addr_ff  <= req_tdata[ADDR_LSB +: ADDR_BITS];
         value_ff <= req_tdata[VALUE_LSB +: PIX_BITS];
         cx_ff    <= req_tdata[CX_LSB +: CX_BITS];
         cy_ff    <= req_tdata[CY_LSB +: CY_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && func_ff == FUNC_BLIT) begin
         w_ff    <= w_clamp;
         h_ff    <= h_clamp;
         x0_ff   <= x0_in;
         y0_ff   <= y0_in;
         r_ff    <= '0;
         c_ff    <= '0;
         clip_ff <= 1'b0;
      end else if (cmd.scan) begin
         if (!inb) begin
            clip_ff <= 1'b1;
         end
         if (c_last) begin
            c_ff <= '0;
            r_ff <= r_ff + SPR_IDX_BITS'(1);
         end else begin
            c_ff <= c_ff + SPR_IDX_BITS'(1);
         end
      end
   end

   // stage one: coordinates of the pixel under the texel
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.scan && inb;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_fx_ff  <= COL_BITS'($unsigned(fx));
      p1_fy_ff  <= ROW_BITS'($unsigned(fy));
      p1_spr_ff <= {r_ff, c_ff};
      p2_idx_ff <= p1_idx;
   end

   always_comb begin
      p1_idx = FRAME_ADDR_BITS'(p1_fy_ff) * FRAME_ADDR_BITS'(FRAME_WIDTH)
             + FRAME_ADDR_BITS'(p1_fx_ff);
      sum = {1'b0, frame_rd_ff} + {1'b0, spr_rd_ff};
      sat = sum[PIX_BITS] ? SAT_MAX : sum[PIX_BITS-1:0];
      frame_in_range = int'(addr_ff) < FRAME_PIXELS;
      spr_in_range   = int'(addr_ff) < SPRITE_TEXELS;
      sw_en   = cmd.exec && func_ff == FUNC_SPRITE_WR && spr_in_range;
      fw_en   = (cmd.exec && func_ff == FUNC_FRAME_WR && frame_in_range) || p2_valid_ff;
      fw_addr = p2_valid_ff ? p2_idx_ff : FRAME_ADDR_BITS'(addr_ff);
      fw_data = p2_valid_ff ? sat : value_ff;
      fr_en   = (cmd.exec && func_ff == FUNC_FRAME_RD && frame_in_range) || p1_valid_ff;
      fr_addr = p1_valid_ff ? p1_idx : FRAME_ADDR_BITS'(addr_ff);
   end

   always_ff @(posedge clock) begin
      if (fw_en) begin
         frame_mem[fw_addr] <= fw_data;
      end
      if (fr_en) begin
         frame_rd_ff <= frame_mem[fr_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (sw_en) begin
         spr_mem[SPR_ADDR_BITS'(addr_ff)] <= value_ff;
      end
      if (p1_valid_ff) begin
         spr_rd_ff <= spr_mem[p1_spr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result) begin
         rsp_data_ff <= (func_ff == FUNC_FRAME_RD && frame_in_range) ? frame_rd_ff : '0;
         rsp_clip_ff <= (func_ff == FUNC_BLIT) && clip_ff;
      end
   end

   assign rsp_tdata = RSP_TDATA_BITS'({rsp_clip_ff, rsp_data_ff});

endmodule

// ----- hw/rtl/additive_saturating_sprite_blit_core.sv -----
// Additive saturating sprite blit. Holds an 8-bit grey frame of 320 x 256 pixels and a
// 32 x 32 sprite store; neither store is cleared at reset, so write before reading. One
// request word gives one response word. A sprite or frame write, a frame read or a blit
// with a zero size passes through a decode state and then a result state, which raises
// rsp_tvalid before the next request is taken; a blit of a clamped w x h sprite goes
// through decode, a scan at one pixel per cycle through the frame memory's single read and
// write port, a drain of the read and write-back stages and a result state. Sprite
// pixels falling off the frame are skipped and flagged as clipped. A new request is taken
// while the previous response still waits on rsp; a held response then stalls the next
// word in its result cycle. The user must write the size registers only while the block
// is idle; the block itself does not enforce this.
module additive_saturating_sprite_blit_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // addr[16:0], value[24:17], center_x[33:25], center_y[41:34], zero fill
   input  logic [asb_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   // func[1:0]
   input  logic [asb_pkg::FUNC_BITS-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // read_data[7:0], clipped[8], zero fill
   output logic [asb_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [asb_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [asb_pkg::CFG_BITS-1:0]        csr_data
);
   import asb_pkg::*;

   asb_cmd_type cmd;
   asb_sts_type sts;

   assign csr_ready = 1'b1;

   asb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   asb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ----- tb/sv/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import asb_pkg::*;

   // register indexes past the end of the map, writes there are dropped
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE_LO = 4'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE_HI = 4'd15;
   localparam int ADDR_TOP = (1 << ADDR_BITS) - 1;
   localparam int CX_TOP   = (1 << CX_BITS) - 1;
   localparam int CY_TOP   = (1 << CY_BITS) - 1;

   // blit centres cluster round corners, edges and middle so the primed area stays small
   localparam int ANCHOR_X [8] = '{0, 319, 0, 319, 160, 160, 0, 319};
   localparam int ANCHOR_Y [8] = '{0, 0, 255, 255, 128, 0, 128, 128};

   typedef struct packed {
      logic                clipped;
      logic [PIX_BITS-1:0] read_data;
   } pixel_answer_type;

   class framebuffer_predictor;
      logic [PIX_BITS-1:0] frame_mem [FRAME_PIXELS];
      bit                  frame_set [FRAME_PIXELS];
      logic [PIX_BITS-1:0] sprite_mem [SPRITE_TEXELS];
      bit                  sprite_set [SPRITE_TEXELS];
      int                  frame_list [$];
      int                  width_reg  = SIZE_RESET;
      int                  height_reg = SIZE_RESET;
      pixel_answer_type    answers [$];
      int                  errors = 0;

      function int size_used(int v);
         return (v > SPRITE_SIZE) ? SPRITE_SIZE : v;
      endfunction

      function void set_reg(logic [CSR_IDX_BITS-1:0] idx, int data);
         if (idx == REG_SPRITE_WIDTH) width_reg = data;
         else if (idx == REG_SPRITE_HEIGHT) height_reg = data;
      endfunction

      function logic run_blit(int cx, int cy);
         int   w, h, x0, y0, r, c, fx, fy, idx, sum;
         logic clip;
         w = size_used(width_reg);
         h = size_used(height_reg);
         x0 = cx - w / 2;
         y0 = cy - h / 2;
         clip = 1'b0;
         for (r = 0; r < h; r++) begin
            for (c = 0; c < w; c++) begin
               fx = x0 + c;
               fy = y0 + r;
               if (fx < 0 || fy < 0 || fx >= FRAME_WIDTH || fy >= FRAME_HEIGHT) begin
                  clip = 1'b1;
               end else begin
                  idx = fy * FRAME_WIDTH + fx;
                  sum = int'(frame_mem[idx]) + int'(sprite_mem[r * SPRITE_SIZE + c]);
                  frame_mem[idx] = (sum > int'(SAT_MAX)) ? SAT_MAX : sum[PIX_BITS-1:0];
               end
            end
         end
         return clip;
      endfunction

      function void note_word(asb_func_type func, int addr, int value, int cx, int cy);
         pixel_answer_type ans;
         ans = '0;
         case (func)
            FUNC_SPRITE_WR: begin
               if (addr < SPRITE_TEXELS) begin
                  sprite_mem[addr] = value[PIX_BITS-1:0];
                  sprite_set[addr] = 1'b1;
               end
            end
            FUNC_FRAME_WR: begin
               if (addr < FRAME_PIXELS) begin
                  if (!frame_set[addr]) begin
                     frame_set[addr] = 1'b1;
                     frame_list.push_back(addr);
                  end
                  frame_mem[addr] = value[PIX_BITS-1:0];
               end
            end
            FUNC_BLIT: begin
               ans.clipped = run_blit(cx, cy);
            end
            default: begin
               if (addr < FRAME_PIXELS) ans.read_data = frame_mem[addr];
            end
         endcase
         answers.push_back(ans);
      endfunction

      task log_mismatch(string what);
         errors++;
         $display("%0t mismatch: %s", $time, what);
      endtask

      task check_word(logic [RSP_TDATA_BITS-1:0] word);
         pixel_answer_type want;
         if (answers.size() == 0) begin
            log_mismatch("response word with nothing outstanding");
            return;
         end
         want = answers.pop_front();
         if (word[PIX_BITS-1:0] !== want.read_data)
            log_mismatch($sformatf("read_data %0d, wanted %0d", word[PIX_BITS-1:0],
                                   want.read_data));
         if (word[PIX_BITS] !== want.clipped)
            log_mismatch($sformatf("clipped %b, wanted %b", word[PIX_BITS], want.clipped));
      endtask

      function int pending();
         return answers.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   // addr[16:0], value[24:17], center_x[33:25], center_y[41:34], zero fill
   logic [REQ_TDATA_BITS-1:0] req_tdata;
   // func[1:0]
   logic [FUNC_BITS-1:0]      req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   // read_data[7:0], clipped[8], zero fill
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_BITS-1:0]   csr_index;
   logic [CFG_BITS-1:0]       csr_data;

   framebuffer_predictor sb;
   int send_gap_pct;
   int take_stall_pct;
   int hold_off = 0;

   additive_saturating_sprite_blit_core uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task send_word(asb_func_type func, int addr, int value, int cx, int cy);
      if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= REQ_TDATA_BITS'({cy[CY_BITS-1:0], cx[CX_BITS-1:0], value[PIX_BITS-1:0],
                                     addr[ADDR_BITS-1:0]});
      do @(posedge clock); while (!req_tready);
      sb.note_word(func, addr, value, cx, cy);
   endtask

   // registers only change once every response is back
   task write_reg(logic [CSR_IDX_BITS-1:0] idx, int data);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data[CFG_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   // fills every texel and frame pixel the blit will read, then issues it
   task blit_at(int cx, int cy);
      int w, h, x0, y0, r, c, fx, fy, idx;
      w = sb.size_used(sb.width_reg);
      h = sb.size_used(sb.height_reg);
      x0 = cx - w / 2;
      y0 = cy - h / 2;
      for (r = 0; r < h; r++) begin
         for (c = 0; c < w; c++) begin
            idx = r * SPRITE_SIZE + c;
            if (!sb.sprite_set[idx])
               send_word(FUNC_SPRITE_WR, idx, $urandom_range(255), $urandom_range(CX_TOP),
                         $urandom_range(CY_TOP));
            fx = x0 + c;
            fy = y0 + r;
            if (fx >= 0 && fy >= 0 && fx < FRAME_WIDTH && fy < FRAME_HEIGHT) begin
               idx = fy * FRAME_WIDTH + fx;
               if (!sb.frame_set[idx])
                  send_word(FUNC_FRAME_WR, idx, $urandom_range(255), $urandom_range(CX_TOP),
                            $urandom_range(CY_TOP));
            end
         end
      end
      send_word(FUNC_BLIT, $urandom_range(ADDR_TOP), $urandom_range(255), cx, cy);
   endtask

   task random_word();
      int k, a, cx, cy;
      k = $urandom_range(99);
      if (k < 15) begin
         if ($urandom_range(9) == 0) begin
            cx = $urandom_range(CX_TOP);
            cy = $urandom_range(CY_TOP);
         end else begin
            a = $urandom_range(7);
            cx = ANCHOR_X[a] + int'($urandom_range(20)) - 10;
            cy = ANCHOR_Y[a] + int'($urandom_range(20)) - 10;
            if (cx < 0) cx = 0;
            if (cy < 0) cy = 0;
            if (cy > CY_TOP) cy = CY_TOP;
         end
         blit_at(cx, cy);
      end else if (k < 32) begin
         a = ($urandom_range(6) == 0) ? $urandom_range(ADDR_TOP, SPRITE_TEXELS)
                                      : $urandom_range(SPRITE_TEXELS - 1);
         send_word(FUNC_SPRITE_WR, a, $urandom_range(255), $urandom_range(CX_TOP),
                   $urandom_range(CY_TOP));
      end else if (k < 55) begin
         a = ($urandom_range(6) == 0) ? $urandom_range(ADDR_TOP, FRAME_PIXELS)
                                      : $urandom_range(FRAME_PIXELS - 1);
         send_word(FUNC_FRAME_WR, a, $urandom_range(255), $urandom_range(CX_TOP),
                   $urandom_range(CY_TOP));
      end else begin
         // reads only hit pixels already written, or fall off the end of the frame
         if (sb.frame_list.size() == 0 || $urandom_range(6) == 0)
            a = $urandom_range(ADDR_TOP, FRAME_PIXELS);
         else
            a = sb.frame_list[$urandom_range(sb.frame_list.size() - 1)];
         send_word(FUNC_FRAME_RD, a, $urandom_range(255), $urandom_range(CX_TOP),
                   $urandom_range(CY_TOP));
      end
   endtask

   task run_phase(int w, int h, int n, int hold);
      write_reg(REG_SPRITE_WIDTH, w);
      write_reg(REG_SPRITE_HEIGHT, h);
      hold_off = hold;
      repeat (n) random_word();
   endtask

   // response side: check, then pick next cycle's ready
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= take_stall_pct);
         end
      end
   end

   initial begin
      #50_000_000;
      $display("** additive_saturating_sprite_blit_core: FAILED **");
      $finish;
   end

   initial begin
      sb = new();
      send_gap_pct   = 14;
      take_stall_pct = 73;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= FUNC_SPRITE_WR;
      csr_valid  <= 1'b0;
      csr_index  <= REG_SPRITE_WIDTH;
      csr_data   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_reg(REG_SPRITE_WIDTH, 4);
      write_reg(REG_SPRITE_HEIGHT, 3);
      write_reg(REG_SPARE_LO, 63);
      write_reg(REG_SPARE_HI, 42);
      send_word(FUNC_SPRITE_WR, 0, 255, 0, 0);
      send_word(FUNC_SPRITE_WR, SPRITE_TEXELS - 1, 0, CX_TOP, CY_TOP);
      send_word(FUNC_SPRITE_WR, SPRITE_TEXELS, 8'h5a, 0, 0);
      send_word(FUNC_SPRITE_WR, ADDR_TOP, 8'ha5, CX_TOP, CY_TOP);
      send_word(FUNC_FRAME_WR, 0, 200, 0, 0);
      send_word(FUNC_FRAME_WR, FRAME_PIXELS - 1, 0, 0, 0);
      send_word(FUNC_FRAME_WR, FRAME_PIXELS, 8'h3c, 0, 0);
      send_word(FUNC_FRAME_WR, ADDR_TOP, 255, 0, 0);
      send_word(FUNC_FRAME_RD, 0, 0, 0, 0);
      send_word(FUNC_FRAME_RD, FRAME_PIXELS - 1, 0, 0, 0);
      send_word(FUNC_FRAME_RD, FRAME_PIXELS, 0, 0, 0);
      send_word(FUNC_FRAME_RD, ADDR_TOP, 0, 0, 0);
      // top-left corner lands on pixel 0 exactly, texel 0 holding 255 saturates it
      blit_at(2, 1);
      send_word(FUNC_FRAME_RD, 0, 0, 0, 0);
      blit_at(0, 0);
      blit_at(FRAME_WIDTH - 1, FRAME_HEIGHT - 1);
      blit_at(FRAME_WIDTH - 2, FRAME_HEIGHT - 2);
      blit_at(CX_TOP, CY_TOP);
      send_word(FUNC_FRAME_RD, FRAME_PIXELS - 1, 0, 0, 0);
      write_reg(REG_SPRITE_WIDTH, 0);
      blit_at(160, 128);
      // width held at the full sprite size, one row
      write_reg(REG_SPRITE_WIDTH, 63);
      write_reg(REG_SPRITE_HEIGHT, 1);
      blit_at(16, 16);
      // height held at the full sprite size, one column hanging off the top
      write_reg(REG_SPRITE_WIDTH, 1);
      write_reg(REG_SPRITE_HEIGHT, 63);
      blit_at(16, 0);

      run_phase(3, 2, 80, 0);
      send_gap_pct   = 73;
      take_stall_pct = 14;
      run_phase(2, 3, 80, 0);
      run_phase(63, 0, 30, 0);
      send_gap_pct   = 0;
      take_stall_pct = 0;
      // long receiver hold-off while words keep coming, so the input side backs up
      run_phase(2, 2, 60, 400);
      run_phase(40, 1, 12, 0);

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (1100) @(posedge clock);
      if (sb.errors == 0) begin
         $display("** additive_saturating_sprite_blit_core: PASSED **");
      end else begin
         $display("** additive_saturating_sprite_blit_core: FAILED **");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
hw/rtl/asb_pkg.sv
hw/rtl/asb_ctrl.sv
hw/rtl/asb_datapath.sv
hw/rtl/additive_saturating_sprite_blit_core.sv
tb/sv/tb.sv
